>>> hw/rtl/fling_drag_decay_step_unit_defines.svh
// assertion macros for the fling drag decay step unit
`ifndef FLING_DRAG_DECAY_STEP_UNIT_DEFINES_SVH
`define FLING_DRAG_DECAY_STEP_UNIT_DEFINES_SVH
`ifndef SYNTH
`define FDD_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fdd assertion failed");
`define FDD_NEVER(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("fdd forbidden condition");
`else
`define FDD_ASSERT(name, prop)
`define FDD_NEVER(name, expr)
`endif
`endif

>>> hw/rtl/fdd_pkg.sv
// shared types and constants of the fling drag decay step unit
package fdd_pkg;
  localparam int unsigned SERIES_TERMS = 13;
  localparam int unsigned MAX_DECAY_STEPS = 32;
  localparam logic [32:0] FX_ONE = 33'h1_0000_0000;
  localparam logic [32:0] RECIP_125 = 33'd1099511627;

  localparam logic [1:0] CFG_DECAY_RATE = 2'd0;
  localparam logic [1:0] CFG_SPEED_THR  = 2'd1;
  localparam logic [1:0] CFG_LOWER      = 2'd2;
  localparam logic [1:0] CFG_UPPER      = 2'd3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XMUL,
    ST_XDIV,
    ST_XWAIT,
    ST_HMUL,
    ST_HDIV,
    ST_HWAIT,
    ST_EMUL,
    ST_ELAT,
    ST_VMUL,
    ST_DMUL,
    ST_DDIV,
    ST_DWAIT
  } state_t;
endpackage

>>> hw/rtl/fdd_mul.sv
// registered 33 by 33 unsigned multiplier
module fdd_mul import fdd_pkg::*; (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [32:0] b,
  output logic [65:0] prod
);
  logic [65:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= {33'b0, a} * {33'b0, b};
  end

  assign prod = prod_r;
endmodule

>>> hw/rtl/fdd_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module fdd_div import fdd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [6:0]  len,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] d_r, d_nxt;
  logic [63:0] q_r, q_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  assign trial = {rem_r, d_r[63]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = len;
      d_nxt    = dividend;
      q_nxt    = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[15:0] : trial[15:0];
      q_nxt   = {q_r[62:0], ge};
      d_nxt   = {d_r[62:0], 1'b0};
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    d_r   <= d_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

>>> hw/rtl/fling_drag_decay_step_unit.sv
// top level: sequencer and datapath of the fling drag decay step unit
// start item: result registered and valid in the cycle after acceptance
// tick item: setup multiplies, 26 series steps, up to 32 decay multiplies and the
// 64-bit rate divider
// one item at a time; ready again in the cycle the result is taken
// synchronous active-low reset: state zero, config and motion registers to defaults, no pending item
module fling_drag_decay_step_unit import fdd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [31:0] in_start_position,
  input  logic signed [31:0] in_start_speed,
  input  logic [15:0]        in_elapsed_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_position_out,
  output logic signed [31:0] out_speed_out,
  output logic               out_finished,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
`include "fling_drag_decay_step_unit_defines.svh"

  state_t state_r, state_nxt;

  logic [15:0]        rate_r;
  logic [30:0]        thr_r;
  logic signed [31:0] lower_r, upper_r;
  logic signed [31:0] pos_r, spd_r;
  logic               out_valid_r;
  logic signed [31:0] out_pos_r, out_spd_r;
  logic               out_fin_r;

  logic [15:0] dt_r;
  logic        neg_r;
  logic [31:0] mag_r;
  logic [36:0] x_r;
  logic [31:0] xp_r;
  logic [32:0] hn_r;
  logic [16:0] r_r;
  logic [3:0]  k_r;
  logic [32:0] p_r;
  logic        pass_r;
  logic [31:0] e1_r;
  logic [32:0] e_r;
  logic [5:0]  cnt_r;
  logic [31:0] vmag_r;

  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;
  logic        div_start;
  logic [63:0] div_dividend;
  logic [6:0]  div_len;
  logic [15:0] div_divisor;
  logic        div_done;
  logic [63:0] quot;

  logic        accept;
  logic [32:0] recip_k;
  logic [14:0] x_lowmul;
  logic [7:0]  x_rem;
  logic        x_corr;
  logic [36:0] x_quot;
  logic [8:0]  h_lowmul;
  logic [4:0]  h_rem;
  logic        h_corr;
  logic [32:0] h_quot;
  logic [32:0] p_new;
  logic [20:0] n_val;
  logic [15:0] rate_eff;
  logic [39:0] dmag;
  logic signed [41:0] sum, lb42, ub42, clamped;
  logic        below;
  logic signed [31:0] spd_new;
  logic        fin_new;

  assign accept   = in_valid && in_ready;
  assign n_val    = x_r[36:16];
  assign rate_eff = (rate_r == 16'd0) ? 16'd1 : rate_r;
  assign dmag     = quot[63:24];

  // reciprocal quotient estimate, then one remainder check
  assign x_lowmul = prod[39:32] * 7'd125;
  assign x_rem    = {xp_r[2:0], 5'b0} - x_lowmul[7:0];
  assign x_corr   = x_rem >= 8'd125;
  assign x_quot   = {5'b0, prod[63:32]} + {36'b0, x_corr};
  assign h_lowmul = prod[36:32] * k_r;
  assign h_rem    = hn_r[4:0] - h_lowmul[4:0];
  assign h_corr   = h_rem >= {1'b0, k_r};
  assign h_quot   = prod[64:32] + {32'b0, h_corr};
  assign p_new    = FX_ONE - h_quot;

  always_comb begin
    case (k_r)
      4'd2:    recip_k = 33'd2147483648;
      4'd3:    recip_k = 33'd1431655765;
      4'd4:    recip_k = 33'd1073741824;
      4'd5:    recip_k = 33'd858993459;
      4'd6:    recip_k = 33'd715827882;
      4'd7:    recip_k = 33'd613566756;
      4'd8:    recip_k = 33'd536870912;
      4'd9:    recip_k = 33'd477218588;
      4'd10:   recip_k = 33'd429496729;
      4'd11:   recip_k = 33'd390451572;
      4'd12:   recip_k = 33'd357913941;
      4'd13:   recip_k = 33'd330382099;
      default: recip_k = FX_ONE;
    endcase
  end

  fdd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  fdd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .len      (div_len),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quot)
  );

  // final position and speed, clamp and finish flag
  always_comb begin
    lb42 = {{10{lower_r[31]}}, lower_r};
    ub42 = {{10{upper_r[31]}}, upper_r};
    if (neg_r) sum = {{10{pos_r[31]}}, pos_r} - $signed({2'b0, dmag});
    else sum = {{10{pos_r[31]}}, pos_r} + $signed({2'b0, dmag});
    if (sum < lb42) clamped = lb42;
    else if (sum > ub42) clamped = ub42;
    else clamped = sum;
    below   = vmag_r < {1'b0, thr_r};
    spd_new = below ? 32'sd0 : (neg_r ? -$signed(vmag_r) : $signed(vmag_r));
    fin_new = below || (clamped <= lb42) || (clamped >= ub42);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_op == OP_TICK) state_nxt = ST_XMUL;
      end
      ST_XMUL: state_nxt = ST_XDIV;
      ST_XDIV: state_nxt = ST_XWAIT;
      ST_XWAIT: state_nxt = ST_HMUL;
      ST_HMUL: state_nxt = ST_HDIV;
      ST_HDIV: state_nxt = ST_HWAIT;
      ST_HWAIT: begin
        if (k_r != 4'd1 || !pass_r) state_nxt = ST_HMUL;
        else if (n_val == 21'd0 || n_val > 21'(MAX_DECAY_STEPS)) state_nxt = ST_VMUL;
        else state_nxt = ST_EMUL;
      end
      ST_EMUL: state_nxt = ST_ELAT;
      ST_ELAT: state_nxt = (cnt_r == 6'd1) ? ST_VMUL : ST_EMUL;
      ST_VMUL: state_nxt = ST_DMUL;
      ST_DMUL: state_nxt = ST_DDIV;
      ST_DDIV: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_len      = 7'd64;
    div_divisor  = 16'd1;
    case (state_r)
      ST_XMUL: begin
        mul_a = {17'b0, rate_r};
        mul_b = {17'b0, dt_r};
      end
      ST_XDIV: begin
        mul_a = {1'b0, prod[31:0]};
        mul_b = RECIP_125;
      end
      ST_HMUL: begin
        mul_a = {16'b0, r_r};
        mul_b = p_r;
      end
      ST_HDIV: begin
        mul_a = prod[48:16];
        mul_b = recip_k;
      end
      ST_EMUL: begin
        mul_a = e_r;
        mul_b = {1'b0, e1_r};
      end
      ST_VMUL: begin
        mul_a = {1'b0, mag_r};
        mul_b = e_r;
      end
      ST_DMUL: begin
        mul_a = {1'b0, mag_r};
        mul_b = FX_ONE - e_r;
      end
      ST_DDIV: begin
        div_start    = 1'b1;
        div_dividend = prod[63:0];
        div_len      = 7'd64;
        div_divisor  = rate_eff;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rate_r      <= 16'd1075;
      thr_r       <= 31'd4096000;
      lower_r     <= 32'sh8000_0000;
      upper_r     <= 32'sh7FFF_FFFF;
      pos_r       <= '0;
      spd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DECAY_RATE: rate_r  <= cfg_wdata[15:0];
          CFG_SPEED_THR:  thr_r   <= cfg_wdata[30:0];
          CFG_LOWER:      lower_r <= cfg_wdata;
          CFG_UPPER:      upper_r <= cfg_wdata;
          default:        rate_r  <= rate_r;
        endcase
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (accept && in_op == OP_START) begin
        pos_r       <= in_start_position;
        spd_r       <= in_start_speed;
        out_valid_r <= 1'b1;
      end
      if (state_r == ST_DWAIT && div_done) begin
        pos_r       <= clamped[31:0];
        spd_r       <= spd_new;
        out_valid_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      dt_r  <= in_elapsed_ms;
      neg_r <= spd_r[31];
      mag_r <= spd_r[31] ? 32'(-spd_r) : spd_r;
      if (in_op == OP_START) begin
        out_pos_r <= in_start_position;
        out_spd_r <= in_start_speed;
        out_fin_r <= 1'b0;
      end
    end
    case (state_r)
      ST_XDIV: xp_r <= prod[31:0];
      ST_XWAIT: begin
        x_r    <= x_quot;
        r_r    <= 17'h1_0000;
        k_r    <= 4'(SERIES_TERMS);
        p_r    <= FX_ONE;
        pass_r <= 1'b0;
      end
      ST_HDIV: hn_r <= prod[48:16];
      ST_HWAIT: begin
        if (k_r != 4'd1) begin
          k_r <= k_r - 4'd1;
          p_r <= p_new;
        end else if (!pass_r) begin
          e1_r   <= p_new[31:0];
          pass_r <= 1'b1;
          r_r    <= {1'b0, x_r[15:0]};
          k_r    <= 4'(SERIES_TERMS);
          p_r    <= FX_ONE;
        end else begin
          e_r   <= (n_val > 21'(MAX_DECAY_STEPS)) ? 33'd0 : p_new;
          cnt_r <= n_val[5:0];
        end
      end
      ST_ELAT: begin
        e_r   <= prod[64:32];
        cnt_r <= cnt_r - 6'd1;
      end
      ST_DMUL: vmag_r <= prod[63:32];
      ST_DWAIT: begin
        if (div_done) begin
          out_pos_r <= clamped[31:0];
          out_spd_r <= spd_new;
          out_fin_r <= fin_new;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_position_out = out_pos_r;
  assign out_speed_out    = out_spd_r;
  assign out_finished     = out_fin_r;

  `FDD_ASSERT(a_ready_idle, in_ready |-> state_r == ST_IDLE)
  `FDD_ASSERT(a_done_in_wait, div_done |-> state_r == ST_DWAIT)
  `FDD_NEVER(a_zero_term, state_r == ST_HDIV && k_r == 4'd0)
  `FDD_ASSERT(a_busy_no_result, (state_r != ST_IDLE && state_r != ST_DWAIT) |-> !out_valid_r)
endmodule

>>> tb/fling_drag_decay_step_unit_checker.sv
// checker of the fling drag decay step unit: predicts every result and compares it
`timescale 1ns / 100ps
module fling_drag_decay_step_unit_checker import fdd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_op,
  input  logic signed [31:0] in_start_position,
  input  logic signed [31:0] in_start_speed,
  input  logic [15:0]        in_elapsed_ms,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_position_out,
  input  logic signed [31:0] out_speed_out,
  input  logic               out_finished,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending_count
);
  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] spd;
    logic               fin;
  } motion_t;

  motion_t motion_q[$];
  logic [15:0] rate_r;
  logic [30:0] thr_r;
  logic signed [63:0] lo_r, hi_r, pos_r, spd_r;

  function automatic logic [63:0] drag_frac(logic [63:0] r);
    logic [63:0] p;
    p = 64'h1_0000_0000;
    for (int k = SERIES_TERMS; k >= 1; k--)
      p = 64'h1_0000_0000 - (((r * p) >> 16) / k);
    return p;
  endfunction

  function automatic logic [63:0] drag_factor(logic [63:0] x);
    logic [63:0] e, e1, n;
    n = x >> 16;
    e = drag_frac(x & 64'hffff);
    e1 = drag_frac(64'd65536);
    if (n > MAX_DECAY_STEPS) return 64'd0;
    for (int i = 0; i < n; i++) e = (e * e1) >> 32;
    return e;
  endfunction

  task automatic advance_fling(input logic op, input logic signed [31:0] sp,
                               input logic signed [31:0] sv, input logic [15:0] dt);
    logic neg, fin;
    logic [63:0] mag, e, x, vmag, dmag, rate;
    logic signed [63:0] sum;
    motion_t m;
    fin = 1'b0;
    if (op == OP_START) begin
      pos_r = sp;
      spd_r = sv;
    end else begin
      rate = (rate_r == 0) ? 64'd1 : 64'(rate_r);
      neg = spd_r < 0;
      mag = neg ? 64'(-spd_r) : 64'(spd_r);
      x = (64'(rate_r) * 64'(dt) * 64'd32) / 64'd125;
      e = drag_factor(x);
      vmag = (mag * e) >> 32;
      dmag = ((mag * (64'h1_0000_0000 - e)) / rate) >> 24;
      sum = neg ? pos_r - $signed(dmag) : pos_r + $signed(dmag);
      if (vmag < 64'(thr_r)) begin
        vmag = 0;
        fin = 1'b1;
      end
      spd_r = neg ? -$signed(vmag) : $signed(vmag);
      if (sum < lo_r) sum = lo_r;
      else if (sum > hi_r) sum = hi_r;
      pos_r = sum;
      if (pos_r <= lo_r || pos_r >= hi_r) fin = 1'b1;
    end
    m.pos = pos_r[31:0];
    m.spd = spd_r[31:0];
    m.fin = fin;
    motion_q.push_back(m);
  endtask

  assign pending_count = motion_q.size();

  always @(posedge clk) begin
    motion_t m;
    if (!rst_n) begin
      rate_r <= 16'd1075;
      thr_r <= 31'd4096000;
      lo_r <= -64'sd2147483648;
      hi_r <= 64'sd2147483647;
      pos_r <= 0;
      spd_r <= 0;
      fail_count <= 0;
      motion_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DECAY_RATE: rate_r <= cfg_wdata[15:0];
          CFG_SPEED_THR:  thr_r <= cfg_wdata[30:0];
          CFG_LOWER:      lo_r <= $signed(cfg_wdata);
          CFG_UPPER:      hi_r <= $signed(cfg_wdata);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (motion_q.size() == 0) begin
          $display("%0t unexpected item pos %h spd %h fin %b", $time,
                   out_position_out, out_speed_out, out_finished);
          fail_count <= fail_count + 1;
        end else begin
          m = motion_q.pop_front();
          if (m.pos !== out_position_out || m.spd !== out_speed_out ||
              m.fin !== out_finished) begin
            $display("%0t mismatch expected pos %h spd %h fin %b actual pos %h spd %h fin %b",
                     $time, m.pos, m.spd, m.fin, out_position_out, out_speed_out,
                     out_finished);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        advance_fling(in_op, in_start_position, in_start_speed, in_elapsed_ms);
    end
  end
endmodule

>>> tb/fling_drag_decay_step_unit_test.sv
// testbench top of the fling drag decay step unit: stimulus, configuration and verdict
`timescale 1ns / 100ps
module fling_drag_decay_step_unit_test;
  import fdd_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_op = OP_START;
  logic signed [31:0] in_start_position = '0;
  logic signed [31:0] in_start_speed = '0;
  logic [15:0]        in_elapsed_ms = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_position_out;
  logic signed [31:0] out_speed_out;
  logic               out_finished;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_DECAY_RATE;
  logic [31:0]        cfg_wdata = '0;
  int                 fail_count;
  int                 pending_count;
  int                 idle_cycles = 0;
  int                 n_start = 0, n_tick = 0;
  logic               stall_free = 1'b0;

  always #1 clk = ~clk;

  fling_drag_decay_step_unit i_dut (.*);
  fling_drag_decay_step_unit_checker i_check (.*);

  function automatic int gap_len();
    if ($urandom_range(9) < 7) return $urandom_range(3, 1);
    return $urandom_range(41, 1);
  endfunction

  always @(posedge clk) begin
    if (stall_free) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(9) < 7) ? 1'b1 : ($urandom_range(30) == 0);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[fling_drag_decay_step_unit] ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [31:0] p, input logic [31:0] v,
                           input logic [15:0] dt);
    int g;
    g = gap_len();
    repeat (g) @(posedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_start_position <= p;
    in_start_speed <= v;
    in_elapsed_ms <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    if (op == OP_START) n_start++; else n_tick++;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'd0;
      default: return 16'($urandom_range(40));
    endcase
  endfunction

  initial begin
    logic [31:0] lo, hi;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_item(OP_TICK, 0, 0, 16);
    send_item(OP_START, 32'h7fffffff, 32'h7fffffff, 0);
    send_item(OP_TICK, 0, 0, 16'hffff);
    send_item(OP_START, 32'h80000000, 32'h80000000, 0);
    send_item(OP_TICK, 0, 0, 1);
    send_item(OP_START, 0, 32'h7fffffff, 0);
    send_item(OP_TICK, 0, 0, 16);
    send_item(OP_TICK, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 16);
    drain();
    write_reg(CFG_DECAY_RATE, 0);
    write_reg(CFG_SPEED_THR, 0);
    write_reg(CFG_LOWER, 32'hfff00000);
    write_reg(CFG_UPPER, 32'h00100000);
    send_item(OP_START, 0, 32'h40000000, 0);
    send_item(OP_TICK, 0, 0, 100);
    send_item(OP_START, 0, 32'hc0000000, 0);
    send_item(OP_TICK, 0, 0, 100);
    drain();
    write_reg(CFG_DECAY_RATE, 16'hffff);
    write_reg(CFG_SPEED_THR, 32'h7fffffff);
    write_reg(CFG_LOWER, 32'h00100000);
    write_reg(CFG_UPPER, 32'hfff00000);
    send_item(OP_START, 32'h00200000, 32'h01000000, 0);
    send_item(OP_TICK, 0, 0, 1);
    send_item(OP_START, 32'h00080000, 32'hff000000, 0);
    send_item(OP_TICK, 0, 0, 1);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      stall_free <= (ph == 3);
      write_reg(CFG_DECAY_RATE, (ph % 4 == 0) ? $urandom_range(1, 16'hffff)
                                              : $urandom_range(100, 3000));
      write_reg(CFG_SPEED_THR, (ph == 5) ? 0 : $urandom_range(8000000));
      lo = $urandom; hi = $urandom;
      if (ph % 3 == 0) begin
        lo = 32'h80000000; hi = 32'h7fffffff;
      end else if ($signed(lo) > $signed(hi) && ph != 7) begin
        {lo, hi} = {hi, lo};
      end
      write_reg(CFG_LOWER, lo);
      write_reg(CFG_UPPER, hi);
      for (int i = 0; i < 240; i++) begin
        if ($urandom_range(7) == 0)
          send_item(OP_START, $urandom, $urandom, 16'($urandom));
        else
          send_item(OP_TICK, $urandom, $urandom, rand_dt());
        if (i == 120) begin
          @(posedge clk);
          while (pending_count != 0) @(posedge clk);
        end
      end
      drain();
    end
    $display("covered %0d start and %0d tick items over eleven register settings",
             n_start, n_tick);
    if (fail_count == 0 && pending_count == 0)
      $display("[fling_drag_decay_step_unit] OK");
    else
      $display("[fling_drag_decay_step_unit] ERROR");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/fdd_pkg.sv
hw/rtl/fdd_mul.sv
hw/rtl/fdd_div.sv
hw/rtl/fling_drag_decay_step_unit.sv
tb/fling_drag_decay_step_unit_checker.sv
tb/fling_drag_decay_step_unit_test.sv
